@@ rtl/core/hrhp_pkg.sv @@
// Types and constants for the HTTP request head parser.
// Parse phases, byte class and status codes, method match text.
// No dependencies.
package hrhp_pkg;

  typedef enum logic [2:0] {
    PH_METHOD,
    PH_TARGET,
    PH_VERSION,
    PH_FIRST_CR,
    PH_SKIP,
    PH_NAME,
    PH_VALUE,
    PH_BODY
  } phase_t;

  typedef logic [2:0] class_t;
  typedef logic [1:0] status_t;
  typedef logic [1:0] method_t;

  localparam class_t CLS_METHOD = 3'd0;
  localparam class_t CLS_TARGET = 3'd1;
  localparam class_t CLS_VERSION = 3'd2;
  localparam class_t CLS_DELIM = 3'd3;
  localparam class_t CLS_NAME = 3'd4;
  localparam class_t CLS_VALUE = 3'd5;
  localparam class_t CLS_BODY = 3'd6;
  localparam class_t CLS_ERROR = 3'd7;

  localparam status_t ST_OK = 2'd0;
  localparam status_t ST_NOT_IMPL = 2'd1;
  localparam status_t ST_BAD_REQ = 2'd2;
  localparam status_t ST_BAD_VER = 2'd3;

  localparam method_t METH_NONE = 2'd0;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [63:0] VERSION_RESET = 64'h485454502F312E31;

  localparam int NUM_METH = 3;

  // "GET ", "POST ", "DELETE "
  localparam logic [7:0] METH_TEXT [NUM_METH][8] = '{
    '{8'h47, 8'h45, 8'h54, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h50, 8'h4F, 8'h53, 8'h54, 8'h20, 8'h00, 8'h00, 8'h00},
    '{8'h44, 8'h45, 8'h4C, 8'h45, 8'h54, 8'h45, 8'h20, 8'h00}
  };
  localparam logic [2:0] METH_LEN [NUM_METH] = '{3'd4, 3'd5, 3'd7};

endpackage

@@ rtl/core/http_request_head_parser.sv @@
// Top level of the HTTP request head parser: byte classifier and checker.
// Depends on hrhp_pkg.
//
// Takes one request byte per cycle and returns one registered result per
// byte, in the cycle after the byte is accepted. The state update and the
// result are computed in a single pass, so a new byte is taken every cycle
// as long as the output register is empty or its result is being taken in
// the same cycle; cfg writes load the expected version text and are always
// taken. The first error latches until the beat flagged end_of_request,
// after which the parser starts over on a new request.
module http_request_head_parser (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [63:0]             cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              data_byte,
  input  logic                    end_of_request,
  output logic                    out_valid,
  input  logic                    out_ready,
  output hrhp_pkg::class_t        byte_class,
  output hrhp_pkg::method_t       method_seen,
  output logic                    done_res,
  output hrhp_pkg::status_t       status
);
  import hrhp_pkg::*;

  logic [63:0]  version_text;
  phase_t       phase, phase_next;
  logic [2:0]   match_pos, match_pos_next;
  logic [2:0]   cand, cand_next;
  method_t      chosen, chosen_next;
  status_t      err, err_next;
  logic         prev_colon, prev_colon_next;
  logic         prev_space, prev_space_next;
  logic         prev_cr, prev_cr_next;
  logic         name_nonempty, name_nonempty_next;
  logic         line_empty, line_empty_next;
  class_t       cls_next;
  logic         accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  always_comb begin
    logic [2:0] keep;
    logic       lf_close;
    logic       do_close;
    logic       open;
    status_t    err_h;
    class_t     cls_h;
    logic [5:0] vbase;
    logic [7:0] want;

    phase_next         = phase;
    match_pos_next     = match_pos;
    cand_next          = cand;
    chosen_next        = chosen;
    err_next           = err;
    prev_colon_next    = prev_colon;
    prev_space_next    = prev_space;
    prev_cr_next       = prev_cr;
    name_nonempty_next = name_nonempty;
    line_empty_next    = line_empty;
    keep               = '0;
    lf_close           = 1'b0;
    cls_h              = CLS_DELIM;
    vbase              = {~match_pos, 3'b000};
    want               = version_text[vbase +: 8];

    if (err == ST_OK) begin
      if (data_byte == CH_LF && phase != PH_BODY) begin
        lf_close = 1'b1;
        cls_h    = CLS_DELIM;
      end else begin
        unique case (phase)
          PH_METHOD: begin
            for (int i = 0; i < NUM_METH; i++) begin
              keep[i] = cand[i] && (match_pos < METH_LEN[i]) &&
                        (METH_TEXT[i][match_pos] == data_byte);
            end
            cand_next      = keep;
            cls_h          = CLS_METHOD;
            match_pos_next = match_pos + 3'd1;
            if (keep == 3'b000) begin
              err_next = ST_NOT_IMPL;
            end else begin
              for (int i = NUM_METH - 1; i >= 0; i--) begin
                if (keep[i] && ({1'b0, METH_LEN[i]} == {1'b0, match_pos} + 4'd1)) begin
                  chosen_next    = method_t'(i + 1);
                  phase_next     = PH_TARGET;
                  match_pos_next = '0;
                  cls_h          = CLS_DELIM;
                end
              end
            end
          end
          PH_TARGET: begin
            if (data_byte == CH_SP) begin
              phase_next     = PH_VERSION;
              match_pos_next = '0;
              cls_h          = CLS_DELIM;
            end else begin
              cls_h = CLS_TARGET;
            end
          end
          PH_VERSION: begin
            cls_h = CLS_VERSION;
            if (want != data_byte) begin
              err_next = ST_BAD_VER;
            end else if (match_pos == 3'd7) begin
              phase_next     = PH_FIRST_CR;
              match_pos_next = '0;
            end else begin
              match_pos_next = match_pos + 3'd1;
            end
          end
          PH_FIRST_CR: begin
            cls_h = CLS_DELIM;
            if (data_byte == CH_CR) begin
              phase_next = PH_SKIP;
            end else begin
              err_next = ST_BAD_REQ;
            end
          end
          PH_SKIP: begin
            cls_h = CLS_DELIM;
          end
          PH_NAME: begin
            line_empty_next = line_empty && (data_byte == CH_CR) && !prev_cr;
            if (prev_colon && data_byte == CH_SP) begin
              prev_colon_next = 1'b0;
              prev_cr_next    = 1'b0;
              cls_h           = CLS_DELIM;
              if (!name_nonempty || prev_space) begin
                err_next = ST_BAD_REQ;
              end else begin
                phase_next = PH_VALUE;
              end
            end else if (data_byte == CH_COLON) begin
              if (prev_colon) begin
                name_nonempty_next = 1'b1;
                prev_space_next    = 1'b0;
              end
              prev_colon_next = 1'b1;
              prev_cr_next    = 1'b0;
              cls_h           = CLS_NAME;
            end else begin
              prev_colon_next    = 1'b0;
              name_nonempty_next = 1'b1;
              prev_space_next    = (data_byte == CH_SP);
              prev_cr_next       = (data_byte == CH_CR);
              cls_h              = (data_byte == CH_CR) ? CLS_DELIM : CLS_NAME;
            end
          end
          PH_VALUE: begin
            prev_cr_next = (data_byte == CH_CR);
            cls_h        = (data_byte == CH_CR) ? CLS_DELIM : CLS_VALUE;
          end
          PH_BODY: begin
            cls_h = CLS_BODY;
          end
          default: begin
            cls_h = CLS_BODY;
          end
        endcase
      end
    end

    err_h = err_next;

    unique case (phase_next)
      PH_BODY: open = 1'b0;
      PH_NAME: open = !line_empty_next || prev_cr_next;
      default: open = 1'b1;
    endcase

    do_close = (err == ST_OK) &&
               (lf_close || (end_of_request && err_h == ST_OK && open));

    if (do_close) begin
      unique case (phase_next)
        PH_METHOD:   err_next = ST_NOT_IMPL;
        PH_TARGET:   err_next = ST_BAD_REQ;
        PH_VERSION:  err_next = ST_BAD_VER;
        PH_FIRST_CR: err_next = ST_BAD_REQ;
        PH_SKIP: begin
          phase_next         = PH_NAME;
          line_empty_next    = 1'b1;
          prev_cr_next       = 1'b0;
          prev_colon_next    = 1'b0;
          prev_space_next    = 1'b0;
          name_nonempty_next = 1'b0;
        end
        PH_NAME: begin
          if (line_empty_next && prev_cr_next) begin
            phase_next = PH_BODY;
          end else begin
            err_next = ST_BAD_REQ;
          end
        end
        PH_VALUE: begin
          if (prev_cr_next) begin
            phase_next         = PH_NAME;
            line_empty_next    = 1'b1;
            prev_cr_next       = 1'b0;
            prev_colon_next    = 1'b0;
            prev_space_next    = 1'b0;
            name_nonempty_next = 1'b0;
          end else begin
            err_next = ST_BAD_REQ;
          end
        end
        default: ;
      endcase
    end

    if (err != ST_OK || err_h != ST_OK || (lf_close && err_next != ST_OK)) begin
      cls_next = CLS_ERROR;
    end else begin
      cls_next = cls_h;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      version_text <= VERSION_RESET;
    end else if (cfg_valid && cfg_ready) begin
      version_text <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_METHOD;
      match_pos     <= '0;
      cand          <= 3'b111;
      chosen        <= METH_NONE;
      err           <= ST_OK;
      prev_colon    <= 1'b0;
      prev_space    <= 1'b0;
      prev_cr       <= 1'b0;
      name_nonempty <= 1'b0;
      line_empty    <= 1'b1;
    end else if (accept) begin
      if (end_of_request) begin
        phase         <= PH_METHOD;
        match_pos     <= '0;
        cand          <= 3'b111;
        chosen        <= METH_NONE;
        err           <= ST_OK;
        prev_colon    <= 1'b0;
        prev_space    <= 1'b0;
        prev_cr       <= 1'b0;
        name_nonempty <= 1'b0;
        line_empty    <= 1'b1;
      end else begin
        phase         <= phase_next;
        match_pos     <= match_pos_next;
        cand          <= cand_next;
        chosen        <= chosen_next;
        err           <= err_next;
        prev_colon    <= prev_colon_next;
        prev_space    <= prev_space_next;
        prev_cr       <= prev_cr_next;
        name_nonempty <= name_nonempty_next;
        line_empty    <= line_empty_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_class  <= cls_next;
      method_seen <= chosen_next;
      done_res    <= end_of_request;
      status      <= err_next;
    end
  end

endmodule

@@ verif/tb_http_request_head_parser.sv @@
// Testbench for http_request_head_parser: byte stream stimulus and result check.
// Holds its own model of the parser in a scoreboard class.
// Depends on hrhp_pkg and the parser RTL.
module tb_http_request_head_parser;
  import hrhp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BYTES = 310;
  localparam int LONG_HOLD = 150;

  typedef struct packed {
    class_t  cls;
    method_t meth;
    logic    done;
    status_t st;
  } head_result_t;

  class head_result_board;
    logic [63:0]  version_text;
    phase_t       phase;
    logic [2:0]   pos;
    logic [2:0]   cand;
    method_t      meth;
    status_t      err;
    bit           prev_colon, prev_space, prev_cr, name_seen, line_empty;
    head_result_t pending[$];
    int unsigned  failures;

    function new();
      version_text = VERSION_RESET;
      failures = 0;
      restart();
    endfunction

    function void restart();
      phase = PH_METHOD;
      pos = '0;
      cand = 3'b111;
      meth = METH_NONE;
      err = ST_OK;
      prev_colon = 0;
      prev_space = 0;
      prev_cr = 0;
      name_seen = 0;
      line_empty = 1;
    endfunction

    function void raise(status_t code);
      if (err == ST_OK) err = code;
    endfunction

    function void new_header_line();
      phase = PH_NAME;
      line_empty = 1;
      prev_cr = 0;
      prev_colon = 0;
      prev_space = 0;
      name_seen = 0;
    endfunction

    function void end_line();
      case (phase)
        PH_METHOD: raise(ST_NOT_IMPL);
        PH_TARGET, PH_FIRST_CR: raise(ST_BAD_REQ);
        PH_VERSION: raise(ST_BAD_VER);
        PH_SKIP: new_header_line();
        PH_NAME: begin
          if (line_empty && prev_cr) phase = PH_BODY;
          else raise(ST_BAD_REQ);
        end
        PH_VALUE: begin
          if (prev_cr) new_header_line();
          else raise(ST_BAD_REQ);
        end
        default: ;
      endcase
    endfunction

    function class_t method_char(logic [7:0] b);
      logic [2:0] keep;
      int i;
      keep = '0;
      if (b == CH_LF) begin
        end_line();
        return CLS_DELIM;
      end
      for (i = 0; i < NUM_METH; i++)
        if (cand[i] && pos < METH_LEN[i] && METH_TEXT[i][pos] == b) keep[i] = 1'b1;
      cand = keep;
      if (keep == '0) begin
        raise(ST_NOT_IMPL);
        return CLS_METHOD;
      end
      for (i = 0; i < NUM_METH; i++) begin
        if (keep[i] && int'(METH_LEN[i]) == int'(pos) + 1) begin
          meth = method_t'(i + 1);
          phase = PH_TARGET;
          pos = '0;
          return CLS_DELIM;
        end
      end
      pos = pos + 3'd1;
      return CLS_METHOD;
    endfunction

    function class_t name_char(logic [7:0] b);
      if (b == CH_LF) begin
        end_line();
        return CLS_DELIM;
      end
      line_empty = line_empty && b == CH_CR && !prev_cr;
      if (prev_colon) begin
        prev_colon = 0;
        if (b == CH_SP) begin
          if (!name_seen || prev_space) raise(ST_BAD_REQ);
          else phase = PH_VALUE;
          prev_cr = 0;
          return CLS_DELIM;
        end
        name_seen = 1;
        prev_space = 0;
      end
      if (b == CH_COLON) begin
        prev_colon = 1;
        prev_cr = 0;
        return CLS_NAME;
      end
      name_seen = 1;
      prev_space = (b == CH_SP);
      prev_cr = (b == CH_CR);
      return (b == CH_CR) ? CLS_DELIM : CLS_NAME;
    endfunction

    function class_t classify(logic [7:0] b);
      logic [7:0] wanted;
      case (phase)
        PH_METHOD: return method_char(b);
        PH_TARGET: begin
          if (b == CH_LF) begin
            end_line();
            return CLS_DELIM;
          end
          if (b == CH_SP) begin
            phase = PH_VERSION;
            pos = '0;
            return CLS_DELIM;
          end
          return CLS_TARGET;
        end
        PH_VERSION: begin
          if (b == CH_LF) begin
            end_line();
            return CLS_DELIM;
          end
          wanted = version_text[8 * (7 - int'(pos)) +: 8];
          if (wanted != b) begin
            raise(ST_BAD_VER);
            return CLS_VERSION;
          end
          if (pos == 3'd7) begin
            phase = PH_FIRST_CR;
            pos = '0;
          end else begin
            pos = pos + 3'd1;
          end
          return CLS_VERSION;
        end
        PH_FIRST_CR: begin
          if (b == CH_CR) begin
            phase = PH_SKIP;
            return CLS_DELIM;
          end
          if (b == CH_LF) begin
            end_line();
            return CLS_DELIM;
          end
          raise(ST_BAD_REQ);
          return CLS_DELIM;
        end
        PH_SKIP: begin
          if (b == CH_LF) new_header_line();
          return CLS_DELIM;
        end
        PH_NAME: return name_char(b);
        PH_VALUE: begin
          if (b == CH_LF) begin
            end_line();
            return CLS_DELIM;
          end
          prev_cr = (b == CH_CR);
          return (b == CH_CR) ? CLS_DELIM : CLS_VALUE;
        end
        default: return CLS_BODY;
      endcase
    endfunction

    function bit line_open();
      if (phase == PH_BODY) return 0;
      if (phase == PH_NAME) return !line_empty || prev_cr;
      return 1;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      head_result_t r;
      if (err != ST_OK) begin
        r.cls = CLS_ERROR;
      end else begin
        r.cls = classify(b);
        if (err != ST_OK) r.cls = CLS_ERROR;
      end
      if (last && err == ST_OK && line_open()) end_line();
      r.meth = meth;
      r.done = last;
      r.st = err;
      pending.push_back(r);
      if (last) restart();
    endfunction

    function void check_result(class_t c, method_t m, logic d, status_t s);
      head_result_t wanted;
      if (pending.size() == 0) begin
        $error("result beat with no byte outstanding");
        failures++;
        return;
      end
      wanted = pending.pop_front();
      if (c !== wanted.cls) begin
        $error("byte_class: expected %0d, actual %0d", wanted.cls, c);
        failures++;
      end
      if (m !== wanted.meth) begin
        $error("method_seen: expected %0d, actual %0d", wanted.meth, m);
        failures++;
      end
      if (d !== wanted.done) begin
        $error("done_res: expected %0d, actual %0d", wanted.done, d);
        failures++;
      end
      if (s !== wanted.st) begin
        $error("status: expected %0d, actual %0d", wanted.st, s);
        failures++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        end_of_request;
  logic        out_valid;
  logic        out_ready;
  class_t      byte_class;
  method_t     method_seen;
  logic        done_res;
  status_t     status;

  head_result_board sb = new();
  logic [7:0]  req_bytes[$];
  int unsigned idle_odds = 0;
  bit          long_hold = 0;
  int unsigned cycles = 0;
  int unsigned bytes_sent = 0;

  http_request_head_parser DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .end_of_request (end_of_request),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .byte_class     (byte_class),
    .method_seen    (method_seen),
    .done_res       (done_res),
    .status         (status)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(byte_class, method_seen, done_res, status);
  end

  // result side: random stall bursts plus one long hold on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        long_hold = 0;
        stall_left = LONG_HOLD;
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(0, 10);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    end_of_request <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_request();
    int i;
    for (i = 0; i < req_bytes.size(); i++)
      send_byte(req_bytes[i], i == req_bytes.size() - 1);
  endtask

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) req_bytes.push_back(s[i]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_version(input logic [63:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.version_text = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly well-formed heads with random content, some broken on purpose
  task automatic build_request();
    int kind, n, i;
    req_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) req_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    kind = $urandom_range(0, 19);
    if (kind < 6) push_text("GET ");
    else if (kind < 12) push_text("POST ");
    else if (kind < 17) push_text("DELETE ");
    else if (kind == 17) push_text("PUT ");
    else if (kind == 18) push_text("DELETX");
    else repeat ($urandom_range(1, 3)) req_bytes.push_back(8'($urandom_range(0, 255)));
    repeat ($urandom_range(0, 6)) req_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
    if ($urandom_range(0, 15) == 0) req_bytes.push_back(8'($urandom_range(0, 255)));
    req_bytes.push_back(CH_SP);
    for (i = 7; i >= 0; i--) req_bytes.push_back(sb.version_text[8 * i +: 8]);
    if ($urandom_range(0, 11) == 0)
      req_bytes[req_bytes.size() - 1 - $urandom_range(0, 7)] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) != 0) req_bytes.push_back(CH_CR);
    else req_bytes.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) req_bytes.push_back(8'($urandom_range(8'h0B, 8'hFF)));
    req_bytes.push_back(CH_LF);
    repeat ($urandom_range(0, 3)) begin
      kind = $urandom_range(0, 15);
      n = (kind == 0) ? 0 : $urandom_range(1, 6);
      repeat (n) req_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
      if (kind == 1) req_bytes.push_back(CH_SP);
      if (kind == 2) req_bytes.push_back(CH_COLON);
      if (kind != 3) begin
        req_bytes.push_back(CH_COLON);
        req_bytes.push_back(CH_SP);
      end
      repeat ($urandom_range(0, 6)) req_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
      if (kind != 4) req_bytes.push_back(CH_CR);
      if (kind == 5) req_bytes.push_back(CH_CR);
      req_bytes.push_back(CH_LF);
    end
    kind = $urandom_range(0, 7);
    if (kind == 1) begin
      req_bytes.push_back(CH_LF);
    end else if (kind != 0) begin
      req_bytes.push_back(CH_CR);
      req_bytes.push_back(CH_LF);
    end
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 5)) req_bytes.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, req_bytes.size());
      while (req_bytes.size() > n) void'(req_bytes.pop_back());
    end
  endtask

  initial begin
    logic [63:0] settings [5];
    int unsigned odds [5];
    int p, start;
    settings = '{VERSION_RESET, 64'h0, '1, 64'h0, 64'h485454502F312E30};
    settings[3] = {$urandom, $urandom};
    odds = '{20, 30, 10, 25, 0};
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    data_byte = '0;
    end_of_request = 1'b0;
    repeat (9) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    for (p = 0; p < 5; p++) begin
      drain();
      write_version(settings[p]);
      idle_odds = odds[p];
      if (p == 0) begin
        send_byte(CH_LF, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        req_bytes.delete();
        push_text("GET \n");
        send_request();
        req_bytes.delete();
        push_text("DELETE  X");
        send_request();
      end
      if (p == 1) long_hold = 1;
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) begin
        build_request();
        send_request();
      end
    end

    drain();
    repeat (10) @(negedge clk);
    if (sb.failures == 0 && sb.pending.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/hrhp_pkg.sv
rtl/core/http_request_head_parser.sv
verif/tb_http_request_head_parser.sv
